// ----- design/sbmq_pkg.sv -----
// Shared types, constants and helpers for the shared-buffer multi-queue block.
// Used by sbmq_ctrl, sbmq_datapath and shared_buffer_multi_queue_core.
// No dependencies.
package sbmq_pkg;

    // Store geometry
    localparam int SLOTS      = 64;
    localparam int NUM_QUEUES = 4;

    // Widths
    localparam int DATA_W = 32;
    localparam int QNUM_W = 3;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    // Pointer value for "no slot"
    localparam logic [PTR_W-1:0] LINK_NULL = PTR_W'(SLOTS);

    // Request kinds
    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } opcode_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_QUEUE = 2'd1,
        ST_NO_SLOT   = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_LINK = 2'd2
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic capture;   // take the input word, start memory reads
        logic commit;    // update pointers, load output register
        logic link_fix;  // second link write: old tail -> new slot
    } ctrl_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic out_busy;  // output register holds a word not taken this cycle
        logic need_link; // current enqueue appends behind an existing tail
    } dp_status_t;

    // True when a pointer names a real slot
    function automatic logic is_slot(input logic [PTR_W-1:0] p);
        return p < PTR_W'(SLOTS);
    endfunction

endpackage

// ----- design/sbmq_ctrl.sv -----
// Sequencer for the shared-buffer multi-queue: accept, execute, optional link fix.
// Depends on sbmq_pkg (state_t, ctrl_cmd_t, dp_status_t).
module sbmq_ctrl
    import sbmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!dp_status.out_busy)
                begin
                    state_next = dp_status.need_link ? S_LINK : S_IDLE;
                end
            end
            S_LINK:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.commit   = 1'b0;
        cmd.link_fix = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_EXEC:
            begin
                cmd.commit = !dp_status.out_busy;
            end
            S_LINK:
            begin
                cmd.link_fix = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/sbmq_datapath.sv -----
// Datapath: queue pointers, free list, link and word stores, output register.
// Depends on sbmq_pkg; driven by commands from sbmq_ctrl.
module sbmq_datapath
    import sbmq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic [3:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic [1:0]        m_tuser,
    output dp_status_t        dp_status
);

    // Pointer state
    logic [PTR_W-1:0] head_reg [NUM_QUEUES];
    logic [PTR_W-1:0] tail_reg [NUM_QUEUES];
    logic [PTR_W-1:0] free_head_reg;

    // Stores
    logic [PTR_W-1:0]  link_mem [SLOTS];
    logic [DATA_W-1:0] word_mem [SLOTS];
    logic [SLOTS-1:0]  link_vld_reg;

    // Captured request
    opcode_t           op_reg;
    logic [QIDX_W-1:0] qidx_reg;
    logic              qok_reg;
    logic [DATA_W-1:0] data_reg;
    logic [PTR_W-1:0]  slot_reg;
    logic [PTR_W-1:0]  head_cap_reg;
    logic [PTR_W-1:0]  tail_cap_reg;
    logic [PTR_W-1:0]  link_q_reg;
    logic              lvld_q_reg;
    logic [DATA_W-1:0] word_q_reg;

    // Deferred tail link write
    logic [SLOT_W-1:0] fix_addr_reg;
    logic [PTR_W-1:0]  fix_data_reg;

    // Output register
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] out_data_reg;
    status_t           out_status_reg;

    // Input decode
    opcode_t           in_op;
    logic [QNUM_W-1:0] in_qnum;
    logic [QNUM_W-1:0] in_qm1;
    logic              in_qok;
    logic [QIDX_W-1:0] in_qidx;
    logic [PTR_W-1:0]  rd_addr;
    logic [SLOT_W-1:0] rd_idx;

    // Execute decode
    logic [PTR_W-1:0]  link_rd;
    logic [PTR_W-1:0]  link_next;
    logic              slot_ok;
    logic              enq_ok;
    logic              deq_ok;
    logic              need_link;
    status_t           res_status;
    logic [SLOT_W-1:0] slot_idx;

    // Link write port
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [PTR_W-1:0]  link_wdata;

    // Decode incoming word; an invalid queue number maps to queue index zero
    always_comb
    begin
        in_op   = opcode_t'(s_tuser[0]);
        in_qnum = s_tuser[3:1];
        in_qm1  = in_qnum - QNUM_W'(1);
        in_qok  = (in_qnum != '0) && (in_qnum <= QNUM_W'(NUM_QUEUES));
        in_qidx = in_qok ? in_qm1[QIDX_W-1:0] : '0;
        rd_addr = (in_op == OP_ENQ) ? free_head_reg : head_reg[in_qidx];
        rd_idx  = rd_addr[SLOT_W-1:0];
    end

    // Capture request and the pointers it needs
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= in_op;
            qidx_reg     <= in_qidx;
            qok_reg      <= in_qok;
            data_reg     <= s_tdata;
            slot_reg     <= rd_addr;
            head_cap_reg <= head_reg[in_qidx];
            tail_cap_reg <= tail_reg[in_qidx];
            lvld_q_reg   <= link_vld_reg[rd_idx];
        end
    end

    // Registered reads of both stores at the chosen slot
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            link_q_reg <= link_mem[rd_idx];
            word_q_reg <= word_mem[rd_idx];
        end
    end

    // Execute: an unwritten link entry reads as its reset value, slot + 1
    always_comb
    begin
        slot_idx  = slot_reg[SLOT_W-1:0];
        link_rd   = lvld_q_reg ? link_q_reg : slot_reg + PTR_W'(1);
        link_next = is_slot(link_rd) ? link_rd : LINK_NULL;
        slot_ok   = is_slot(slot_reg);
        enq_ok    = qok_reg && (op_reg == OP_ENQ) && slot_ok;
        deq_ok    = qok_reg && (op_reg == OP_DEQ) && slot_ok;
        need_link = enq_ok && is_slot(head_cap_reg) && is_slot(tail_cap_reg);
        if (!qok_reg)
        begin
            res_status = ST_BAD_QUEUE;
        end
        else if (slot_ok)
        begin
            res_status = ST_OK;
        end
        else if (op_reg == OP_ENQ)
        begin
            res_status = ST_NO_SLOT;
        end
        else
        begin
            res_status = ST_EMPTY;
        end
    end

    // Link store write port
    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = slot_idx;
        link_wdata = LINK_NULL;
        if (cmd.commit && enq_ok)
        begin
            link_we = 1'b1;
        end
        else if (cmd.commit && deq_ok)
        begin
            link_we    = 1'b1;
            link_wdata = free_head_reg;
        end
        else if (cmd.link_fix)
        begin
            link_we    = 1'b1;
            link_waddr = fix_addr_reg;
            link_wdata = fix_data_reg;
        end
    end

    // Store writes
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.commit && enq_ok)
        begin
            word_mem[slot_idx] <= data_reg;
        end
    end

    // Link valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg <= '0;
        end
        else if (link_we)
        begin
            link_vld_reg[link_waddr] <= 1'b1;
        end
    end

    // Queue pointers and free list head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= LINK_NULL;
                tail_reg[i] <= LINK_NULL;
            end
            free_head_reg <= '0;
        end
        else if (cmd.commit && enq_ok)
        begin
            free_head_reg <= link_next;
            if (!is_slot(head_cap_reg))
            begin
                head_reg[qidx_reg] <= slot_reg;
            end
            tail_reg[qidx_reg] <= slot_reg;
        end
        else if (cmd.commit && deq_ok)
        begin
            head_reg[qidx_reg] <= link_next;
            free_head_reg      <= slot_reg;
        end
    end

    // Remember old tail for the second link write
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            fix_addr_reg <= tail_cap_reg[SLOT_W-1:0];
            fix_data_reg <= slot_reg;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg <= res_status;
            out_data_reg   <= deq_ok ? word_q_reg : '1;
        end
    end

    assign m_tvalid            = m_tvalid_reg;
    assign m_tdata             = out_data_reg;
    assign m_tuser             = out_status_reg;
    assign dp_status.out_busy  = m_tvalid_reg && !m_tready;
    assign dp_status.need_link = need_link;

endmodule

// ----- design/shared_buffer_multi_queue_core.sv -----
// Several FIFO queues sharing one slot store, linked through a free list.
// The cycle in which a word is accepted reads the head or free pointer and starts the
// registered link/word store reads; the execute state then updates the lists and loads the
// result into the output register, waiting while the previous result is not taken. An enqueue
// that appends behind a non-empty queue also passes through the link state, since the single
// link store write port must also update the old tail's link. A new word is not accepted until
// the previous one has left these states. Link store entries not yet written read as their
// reset value through per-slot valid bits, so no clearing pass is needed.
// Depends on sbmq_pkg, sbmq_ctrl and sbmq_datapath.
module shared_buffer_multi_queue_core
    import sbmq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] data_in
    input  logic [3:0]        s_tuser,   // [0] opcode, [3:1] queue_num
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] data_out
    output logic [1:0]        m_tuser    // [1:0] status
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // Sequencer
    sbmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // Lists, stores and output register
    sbmq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .dp_status (dp_status)
    );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for shared_buffer_multi_queue_core: a clocked driver and monitor
// around the block, with a slot/free-list predictor run on every accepted request word.
// Depends on sbmq_pkg and the design files under design/.
`timescale 1ns / 100ps

module testbench;
    import sbmq_pkg::*;

    localparam int N_RANDOM  = 1550;
    localparam int CHUNK_LEN = 100;
    localparam int DRAIN_MAX = 5000;

    // One request as it goes onto the slave side
    typedef struct {
        opcode_t     op;
        logic [2:0]  qnum;
        logic [31:0] data;
        int          phase;
    } req_word_t;

    // One result as the master side should return it
    typedef struct {
        status_t     status;
        logic [31:0] data;
    } queue_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;  // [31:0] data_in
    logic [3:0]        s_tuser = '0;  // [0] opcode, [3:1] queue_num
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;       // [31:0] data_out
    logic [1:0]        m_tuser;       // [1:0] status

    req_word_t     pending_reqs[$];
    queue_result_t owed_results[$];
    req_word_t     word_on_bus;
    int            rx_stall_pct = 0;
    int            err_count = 0;

    // Predictor state: per-queue head/tail, link store, word store, free list head
    logic [PTR_W-1:0] q_head[NUM_QUEUES];
    logic [PTR_W-1:0] q_tail[NUM_QUEUES];
    logic [PTR_W-1:0] slot_link[SLOTS];
    logic [31:0]      slot_word[SLOTS];
    logic [PTR_W-1:0] free_top;

    shared_buffer_multi_queue_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 100)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // Apply one request to the predicted lists and return its result
    function automatic queue_result_t serve_request(input req_word_t r);
        queue_result_t    res;
        int               qi;
        logic [PTR_W-1:0] slot;
        res.status = ST_OK;
        res.data   = '1;
        qi         = int'(r.qnum) - 1;
        if (r.qnum == 3'd0 || int'(r.qnum) > NUM_QUEUES) begin
            res.status = ST_BAD_QUEUE;
        end else if (r.op == OP_ENQ) begin
            slot = free_top;
            if (slot >= PTR_W'(SLOTS)) begin
                res.status = ST_NO_SLOT;
            end else begin
                free_top = (slot_link[slot] < PTR_W'(SLOTS)) ? slot_link[slot] : LINK_NULL;
                if (q_head[qi] >= PTR_W'(SLOTS))
                    q_head[qi] = slot;
                else if (q_tail[qi] < PTR_W'(SLOTS))
                    slot_link[q_tail[qi]] = slot;
                slot_link[slot] = LINK_NULL;
                q_tail[qi]      = slot;
                slot_word[slot] = r.data;
            end
        end else begin
            slot = q_head[qi];
            if (slot >= PTR_W'(SLOTS)) begin
                res.status = ST_EMPTY;
            end else begin
                q_head[qi]      = (slot_link[slot] < PTR_W'(SLOTS)) ? slot_link[slot] : LINK_NULL;
                slot_link[slot] = free_top;
                free_top        = slot;
                res.data        = slot_word[slot];
            end
        end
        return res;
    endfunction

    function automatic req_word_t make_req(input opcode_t op, input int q, input logic [31:0] d);
        req_word_t r;
        r.op    = op;
        r.qnum  = 3'(q);
        r.data  = d;
        r.phase = 0;
        return r;
    endfunction

    // Random request: mostly valid queues, some extreme words
    function automatic req_word_t rand_req(input int enq_pct, input int ph);
        req_word_t r;
        int        pick;
        int        bad;
        r.op  = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        pick  = $urandom_range(99);
        if (pick < 8) begin
            bad    = $urandom_range(3);
            r.qnum = (bad == 0) ? 3'd0 : 3'(NUM_QUEUES + bad);
        end else begin
            r.qnum = 3'($urandom_range(NUM_QUEUES, 1));
        end
        pick = $urandom_range(99);
        if (pick < 5)
            r.data = 32'h8000_0000;
        else if (pick < 10)
            r.data = 32'h7FFF_FFFF;
        else if (pick < 13)
            r.data = 32'h0000_0000;
        else if (pick < 16)
            r.data = 32'hFFFF_FFFF;
        else
            r.data = $urandom;
        r.phase = ph;
        return r;
    endfunction

    // Sender idle percentage per phase
    function automatic int tx_idle_pct(input int ph);
        return (ph == 0) ? 37 : (ph == 1) ? 83 : 0;
    endfunction

    function automatic int rx_idle_pct(input int ph);
        return (ph == 0) ? 83 : (ph == 1) ? 37 : 0;
    endfunction

    // Driver: predicts on acceptance, then offers the next pending word or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                owed_results.push_back(serve_request(word_on_bus));
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 &&
                    $urandom_range(99) >= tx_idle_pct(pending_reqs[0].phase)) begin
                    word_on_bus  = pending_reqs.pop_front();
                    rx_stall_pct = rx_idle_pct(word_on_bus.phase);
                    s_tvalid <= 1'b1;
                    s_tdata  <= word_on_bus.data;
                    s_tuser  <= {word_on_bus.qnum, word_on_bus.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest owed one
    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t exp_res;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing owed: status %0d data %h",
                                              m_tuser, m_tdata));
                end else begin
                    exp_res = owed_results.pop_front();
                    if (m_tuser !== exp_res.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_tuser, exp_res.status));
                    if (m_tdata !== exp_res.data)
                        report_mismatch($sformatf("data_out got %h want %h",
                                                  m_tdata, exp_res.data));
                end
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int enq_pct;
        int drain;
        // predictor reset
        for (int i = 0; i < NUM_QUEUES; i++) begin
            q_head[i] = LINK_NULL;
            q_tail[i] = LINK_NULL;
        end
        for (int i = 0; i < SLOTS; i++) begin
            slot_link[i] = PTR_W'(i + 1);
            slot_word[i] = '0;
        end
        slot_link[SLOTS-1] = LINK_NULL;
        free_top           = '0;

        // directed: invalid queues, empty queue, extreme words, emptied queue reuse
        pending_reqs.push_back(make_req(OP_DEQ, 1, 32'h0));
        pending_reqs.push_back(make_req(OP_ENQ, 0, 32'h1234_5678));
        pending_reqs.push_back(make_req(OP_DEQ, 0, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(OP_ENQ, 5, 32'h0));
        pending_reqs.push_back(make_req(OP_ENQ, 6, 32'h5555_5555));
        pending_reqs.push_back(make_req(OP_DEQ, 7, 32'hAAAA_AAAA));
        pending_reqs.push_back(make_req(OP_ENQ, 1, 32'h7FFF_FFFF));
        pending_reqs.push_back(make_req(OP_ENQ, 1, 32'h8000_0000));
        pending_reqs.push_back(make_req(OP_ENQ, 1, 32'h0000_0000));
        pending_reqs.push_back(make_req(OP_ENQ, 1, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(OP_ENQ, NUM_QUEUES, 32'hAAAA_AAAA));
        pending_reqs.push_back(make_req(OP_ENQ, 2, 32'h5555_5555));
        pending_reqs.push_back(make_req(OP_ENQ, 3, 32'h0000_0001));
        for (int i = 0; i < 5; i++)
            pending_reqs.push_back(make_req(OP_DEQ, 1, 32'h0));
        pending_reqs.push_back(make_req(OP_ENQ, 1, 32'hDEAD_BEEF));
        pending_reqs.push_back(make_req(OP_DEQ, 1, 32'h0));
        pending_reqs.push_back(make_req(OP_DEQ, NUM_QUEUES, 32'h0));
        pending_reqs.push_back(make_req(OP_DEQ, NUM_QUEUES, 32'h0));
        pending_reqs.push_back(make_req(OP_DEQ, 2, 32'h0));
        pending_reqs.push_back(make_req(OP_DEQ, 3, 32'h0));

        // random: chunks with an enqueue bias so the store fills up and drains
        enq_pct = 50;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % CHUNK_LEN == 0) begin
                case ($urandom_range(3))
                    0:       enq_pct = 15;
                    1:       enq_pct = 90;
                    default: enq_pct = 50;
                endcase
            end
            pending_reqs.push_back(rand_req(enq_pct, (i * 3) / N_RANDOM));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || s_tvalid)
            @(negedge clk);
        drain = 0;
        while (owed_results.size() > 0 && drain < DRAIN_MAX) begin
            @(negedge clk);
            drain++;
        end
        repeat (10) @(negedge clk);
        if (owed_results.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
